// ===== hdl/page_frame_bitmap_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// page frame allocator assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PFBA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PFBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pfba_pkg.sv =====
// ----------------------------------------------------------------------------
// pfba_pkg
// types and constants shared by the page frame allocator modules
// ----------------------------------------------------------------------------
package pfba_pkg;

    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int IDX_W      = ADDR_W - PAGE_SHIFT;
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = 5;
    localparam int RANGE_W    = 11;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam int DEF_MAP_FRAMES = 1024;
    localparam int DEF_BATCH_SIZE = 20;

    localparam logic [RANGE_W-1:0]  RANGE_RESET = 11'd1024;
    localparam logic [ADDR_W-1:0]   BASE_RESET  = 32'h0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RANGE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] free_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0]   frame_address;
        logic [STATUS_W-1:0] status;
    } t_resp;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_map_ctl;

    typedef struct packed {
        logic hit;
        logic [BIT_W-1:0] bit_idx;
    } t_scan;

    typedef struct packed {
        logic rd;
        logic wr;
        logic wr_ok;
    } t_batch_ctl;

endpackage

// ===== hdl/pfba_map.sv =====
// ----------------------------------------------------------------------------
// pfba_map
// used-frame bitmap memory, one word per 32 frames, with first-free search
// ----------------------------------------------------------------------------
module pfba_map #(
    parameter int MAP_FRAMES = pfba_pkg::DEF_MAP_FRAMES,
    parameter int MAP_WORDS  = (MAP_FRAMES + pfba_pkg::WORD_BITS - 1) / pfba_pkg::WORD_BITS,
    parameter int MW_A       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  logic                            i_clk,
    input  pfba_pkg::t_map_ctl              i_ctl,
    input  logic [MW_A-1:0]                 i_addr,
    input  logic [pfba_pkg::WORD_BITS-1:0]  i_wdata,
    input  logic [pfba_pkg::IDX_W-1:0]      i_managed,
    output logic [pfba_pkg::WORD_BITS-1:0]  o_rdata,
    output pfba_pkg::t_scan                 o_scan
);
    import pfba_pkg::*;

    logic [WORD_BITS-1:0] r_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic [MW_A-1:0]      r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata   <= r_mem[i_addr];
            r_rd_addr <= i_addr;
        end
    end

    assign o_rdata = r_rdata;

    // lowest clear bit whose frame index lies below the managed count
    always_comb begin
        logic [IDX_W-1:0]     word_base;
        logic [WORD_BITS-1:0] free_vec;
        word_base = IDX_W'(r_rd_addr) << BIT_W;
        o_scan    = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            free_vec[b] = ~r_rdata[b] && ((word_base | IDX_W'(b)) < i_managed);
        end
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                o_scan.hit     = 1'b1;
                o_scan.bit_idx = BIT_W'(b);
            end
        end
    end

endmodule

// ===== hdl/pfba_batch.sv =====
// ----------------------------------------------------------------------------
// pfba_batch
// batch of reserved frame addresses with per-slot valid flags
// ----------------------------------------------------------------------------
module pfba_batch #(
    parameter int BATCH_SIZE = pfba_pkg::DEF_BATCH_SIZE,
    parameter int BI_W       = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfba_pkg::t_batch_ctl          i_ctl,
    input  logic [BI_W-1:0]               i_wr_slot,
    input  logic [pfba_pkg::ADDR_W-1:0]   i_wr_frame,
    input  logic [BI_W-1:0]               i_rd_slot,
    output logic [pfba_pkg::ADDR_W-1:0]   o_rd_frame,
    output logic                          o_rd_ok
);
    import pfba_pkg::*;

    logic [ADDR_W-1:0]     r_mem [BATCH_SIZE];
    logic [BATCH_SIZE-1:0] r_valid;
    logic [ADDR_W-1:0]     r_rd_frame;
    logic                  r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_slot] <= i_wr_frame;
        end
        if (i_ctl.rd) begin
            r_rd_frame <= r_mem[i_rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_ctl.wr) begin
                r_valid[i_wr_slot] <= i_ctl.wr_ok;
            end
            if (i_ctl.rd) begin
                r_rd_ok <= r_valid[i_rd_slot];
            end
        end
    end

    assign o_rd_frame = r_rd_frame;
    assign o_rd_ok    = r_rd_ok;

endmodule

// ===== hdl/page_frame_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// physical page frame allocator over a one-bit-per-frame used map
// ----------------------------------------------------------------------------
// requests enter on i_in_valid / o_in_stall with a t_req payload: allocate
// hands out the next frame of a reserved batch, free clears the frame's map
// bit. each request gives exactly one t_resp on o_out_valid / i_out_stall.
// requests are handled one at a time: the next one is taken only after the
// result has moved on to the output register. an allocate served from the
// batch passes S_HAND_RD, S_HAND_DAT and S_DONE, an in-range free passes
// S_FREE_CHK, S_FREE_RD and S_DONE, a free outside the map S_FREE_CHK and
// S_DONE. an allocate that finds the batch used up first refills it: each
// slot takes S_SCAN_RD, S_SCAN_EV and S_SCAN_WR (only S_SCAN_RD once the map
// is exhausted), and every map word (32 frames) that holds no free frame adds
// S_SCAN_RD and S_SCAN_EV; the single map port serializes these steps. after
// reset the used map is cleared one word per cycle with o_in_stall high;
// configuration writes are taken during that pass. a result waits in the
// output register while the receiver stalls, and the next request is still accepted meanwhile.
// configuration: i_cfg_we with i_cfg_idx 0 writes frame_base, 1 writes
// frames_in_use_range; write only while no request is in flight.
// ----------------------------------------------------------------------------
`include "page_frame_bitmap_allocator_defines.svh"

module page_frame_bitmap_allocator #(
    parameter int MAP_FRAMES = pfba_pkg::DEF_MAP_FRAMES,
    parameter int BATCH_SIZE = pfba_pkg::DEF_BATCH_SIZE
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pfba_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pfba_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  pfba_pkg::t_req                   i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output pfba_pkg::t_resp                  o_out_data
);
    import pfba_pkg::*;

    localparam int MAP_WORDS = (MAP_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int MW_A      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WC_W      = $clog2(MAP_WORDS + 1);
    localparam int BI_W      = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
    localparam int NC_W      = $clog2(BATCH_SIZE + 1);

    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_FREE_CHK = 4'd2;
    localparam logic [3:0] S_FREE_RD  = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_EV  = 4'd5;
    localparam logic [3:0] S_SCAN_WR  = 4'd6;
    localparam logic [3:0] S_HAND_RD  = 4'd7;
    localparam logic [3:0] S_HAND_DAT = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0]         r_state, n_state;
    logic [ADDR_W-1:0]  r_base;
    logic [RANGE_W-1:0] r_range;
    t_req               r_req, n_req;
    logic [IDX_W-1:0]   r_fidx, n_fidx;
    logic [WC_W-1:0]    r_word, n_word;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [NC_W-1:0]    r_slot, n_slot;
    logic [NC_W-1:0]    r_next, n_next;
    logic [MW_A-1:0]    r_clr, n_clr;
    t_resp              r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_resp              r_out, n_out;

    logic [IDX_W-1:0]     w_managed;
    logic [IDX_W-1:0]     w_word_base;
    logic [ADDR_W-1:0]    w_free_off;
    logic [IDX_W-1:0]     w_free_idx;
    logic [IDX_W-1:0]     w_scan_idx;
    logic [ADDR_W-1:0]    w_alloc_addr;
    logic                 w_out_free;

    t_map_ctl             w_map_ctl;
    logic [MW_A-1:0]      w_map_addr;
    logic [WORD_BITS-1:0] w_map_wdata;
    logic [WORD_BITS-1:0] w_map_rdata;
    t_scan                w_scan;

    t_batch_ctl           w_bat_ctl;
    logic [ADDR_W-1:0]    w_bat_frame;
    logic                 w_bat_ok;

    pfba_map #(
        .MAP_FRAMES (MAP_FRAMES),
        .MAP_WORDS  (MAP_WORDS),
        .MW_A       (MW_A)
    ) u_map (
        .i_clk     (i_clk),
        .i_ctl     (w_map_ctl),
        .i_addr    (w_map_addr),
        .i_wdata   (w_map_wdata),
        .i_managed (w_managed),
        .o_rdata   (w_map_rdata),
        .o_scan    (w_scan)
    );

    pfba_batch #(
        .BATCH_SIZE (BATCH_SIZE),
        .BI_W       (BI_W)
    ) u_batch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_bat_ctl),
        .i_wr_slot  (r_slot[BI_W-1:0]),
        .i_wr_frame (w_alloc_addr),
        .i_rd_slot  (r_next[BI_W-1:0]),
        .o_rd_frame (w_bat_frame),
        .o_rd_ok    (w_bat_ok)
    );

    // managed count, clamped to the map capacity
    assign w_managed = (IDX_W'(r_range) > IDX_W'(MAP_FRAMES)) ? IDX_W'(MAP_FRAMES)
                                                               : IDX_W'(r_range);

    assign w_word_base  = IDX_W'(r_word) << BIT_W;
    assign w_free_off   = r_req.free_address - r_base;
    assign w_free_idx   = w_free_off[ADDR_W-1:PAGE_SHIFT];
    assign w_scan_idx   = w_word_base | IDX_W'(r_bit);
    assign w_alloc_addr = r_base + (ADDR_W'(w_scan_idx) << PAGE_SHIFT);
    assign w_out_free   = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_fidx      = r_fidx;
        n_word      = r_word;
        n_bit       = r_bit;
        n_slot      = r_slot;
        n_next      = r_next;
        n_clr       = r_clr;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_map_ctl   = '0;
        w_map_addr  = r_word[MW_A-1:0];
        w_map_wdata = '0;
        w_bat_ctl   = '0;

        case (r_state)
            S_CLR: begin
                w_map_ctl.wr = 1'b1;
                w_map_addr   = r_clr;
                n_clr        = r_clr + 1'b1;
                if (r_clr == MW_A'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in_data;
                    if (i_in_data.req_type == REQ_FREE) begin
                        n_state = S_FREE_CHK;
                    end else if (r_next >= NC_W'(BATCH_SIZE)) begin
                        n_word  = '0;
                        n_slot  = '0;
                        n_state = S_SCAN_RD;
                    end else begin
                        n_state = S_HAND_RD;
                    end
                end
            end
            S_FREE_CHK: begin
                n_fidx = w_free_idx;
                if (w_free_idx < w_managed) begin
                    w_map_ctl.rd = 1'b1;
                    w_map_addr   = w_free_idx[BIT_W +: MW_A];
                    n_state      = S_FREE_RD;
                end else begin
                    n_res.frame_address = '0;
                    n_res.status        = ST_RANGE;
                    n_state             = S_DONE;
                end
            end
            S_FREE_RD: begin
                w_map_ctl.wr = 1'b1;
                w_map_addr   = r_fidx[BIT_W +: MW_A];
                w_map_wdata  = w_map_rdata & ~(WORD_BITS'(1) << r_fidx[BIT_W-1:0]);
                n_res.frame_address = '0;
                n_res.status        = ST_OK;
                n_state             = S_DONE;
            end
            S_SCAN_RD: begin
                if (w_word_base >= w_managed) begin
                    // map exhausted: this slot stays empty
                    w_bat_ctl.wr = 1'b1;
                    n_slot       = r_slot + 1'b1;
                    if (r_slot == NC_W'(BATCH_SIZE - 1)) begin
                        n_next  = '0;
                        n_state = S_HAND_RD;
                    end
                end else begin
                    w_map_ctl.rd = 1'b1;
                    n_state      = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                if (w_scan.hit) begin
                    n_bit   = w_scan.bit_idx;
                    n_state = S_SCAN_WR;
                end else begin
                    n_word  = r_word + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_WR: begin
                // later scans of this refill resume at the same word
                w_map_ctl.wr    = 1'b1;
                w_map_wdata     = w_map_rdata | (WORD_BITS'(1) << r_bit);
                w_bat_ctl.wr    = 1'b1;
                w_bat_ctl.wr_ok = 1'b1;
                n_slot          = r_slot + 1'b1;
                if (r_slot == NC_W'(BATCH_SIZE - 1)) begin
                    n_next  = '0;
                    n_state = S_HAND_RD;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_HAND_RD: begin
                w_bat_ctl.rd = 1'b1;
                n_state      = S_HAND_DAT;
            end
            S_HAND_DAT: begin
                n_next = r_next + 1'b1;
                if (w_bat_ok) begin
                    n_res.frame_address = w_bat_frame;
                    n_res.status        = ST_OK;
                end else begin
                    n_res.frame_address = '0;
                    n_res.status        = ST_NONE;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_next      <= NC_W'(BATCH_SIZE);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_next      <= n_next;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_fidx <= n_fidx;
        r_word <= n_word;
        r_bit  <= n_bit;
        r_slot <= n_slot;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BASE_RESET;
            r_range <= RANGE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_BASE:  r_base  <= i_cfg_data[ADDR_W-1:0];
                CFG_FRAME_RANGE: r_range <= i_cfg_data[RANGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    `PFBA_ASSERT_SAME(a_next_bound, i_clk, i_rst_n, 1'b1, r_next <= NC_W'(BATCH_SIZE), "batch pointer past batch end")
    `PFBA_ASSERT_SAME(a_scan_free, i_clk, i_rst_n, r_state == S_SCAN_WR, !w_map_rdata[r_bit], "scan claimed a used frame")
    `PFBA_ASSERT_SAME(a_free_range, i_clk, i_rst_n, r_state == S_FREE_RD, r_fidx < w_managed, "free write outside managed frames")
    `PFBA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state != S_IDLE && r_state != S_CLR, "accepted transaction not in progress")

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// page frame allocator: directed and random alloc/free requests, with each
// response predicted from a behavioral copy of the used map and the batch
// and compared in order, field by field
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pfba_pkg::*;

    localparam int MAP_FRAMES  = DEF_MAP_FRAMES;
    localparam int BATCH_SIZE  = DEF_BATCH_SIZE;
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT     = 300;
    localparam int DRAIN_WAIT  = 20;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_FRAME_BASE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_req                  in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_resp                 out_data;

    page_frame_bitmap_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted allocator state
    logic               frame_used [MAP_FRAMES];
    logic [ADDR_W-1:0]  batch_addr [BATCH_SIZE];
    logic               batch_ok   [BATCH_SIZE];
    int                 batch_pos;
    logic [ADDR_W-1:0]  base_reg;
    logic [RANGE_W-1:0] range_reg;

    t_req  req_q [$];
    t_resp due_q [$];
    int    n_accepted = 0;
    int    mismatches = 0;

    function automatic int managed_frames();
        int n;
        n = int'(range_reg);
        if (n > MAP_FRAMES)
            n = MAP_FRAMES;
        return n;
    endfunction

    task automatic claim_first_free(output logic found, output logic [ADDR_W-1:0] addr);
        int n;
        n     = managed_frames();
        found = 1'b0;
        addr  = '0;
        for (int i = 0; i < n && !found; i++) begin
            if (!frame_used[i]) begin
                frame_used[i] = 1'b1;
                addr  = base_reg + (ADDR_W'(i) << PAGE_SHIFT);
                found = 1'b1;
            end
        end
    endtask

    task automatic serve_request(input t_req req, output t_resp rsp);
        logic              found;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] idx;
        rsp.frame_address = '0;
        rsp.status        = ST_OK;
        if (req.req_type == REQ_ALLOC) begin
            if (batch_pos >= BATCH_SIZE) begin
                for (int k = 0; k < BATCH_SIZE; k++) begin
                    claim_first_free(found, addr);
                    batch_addr[k] = addr;
                    batch_ok[k]   = found;
                end
                batch_pos = 0;
            end
            // an empty slot is consumed all the same
            if (batch_ok[batch_pos])
                rsp.frame_address = batch_addr[batch_pos];
            else
                rsp.status = ST_NONE;
            batch_pos++;
        end else begin
            // below base wraps to a huge index
            idx = (req.free_address - base_reg) >> PAGE_SHIFT;
            if (idx < ADDR_W'(managed_frames()))
                frame_used[idx] = 1'b0;
            else
                rsp.status = ST_RANGE;
        end
    endtask

    function automatic t_req random_request();
        t_req r;
        int   n;
        int   span;
        int   pick;
        n    = managed_frames();
        // batches come from the low frames, so frees aim there most of the time
        span = (n < 62) ? n + 2 : 64;
        pick = $urandom_range(9);
        r.req_type     = ($urandom_range(99) < 55) ? REQ_ALLOC : REQ_FREE;
        r.free_address = $urandom();
        if (r.req_type == REQ_FREE) begin
            if (pick < 6)
                r.free_address = base_reg + ($urandom_range(span) << PAGE_SHIFT)
                                 + $urandom_range(4095);
            else if (pick < 8)
                r.free_address = base_reg + ($urandom_range(n + 2) << PAGE_SHIFT)
                                 + $urandom_range(4095);
            else if (pick == 8)
                r.free_address = base_reg - $urandom_range(1, 32'h000F_FFFF);
        end
        return r;
    endfunction

    function automatic t_req make_req(input logic kind, input logic [ADDR_W-1:0] addr);
        t_req r;
        r.req_type     = kind;
        r.free_address = addr;
        return r;
    endfunction

    task automatic write_cfg(input logic [ADDR_W-1:0] base, input logic [RANGE_W-1:0] range);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_FRAME_BASE;
        cfg_data <= base;
        @(negedge i_clk);
        cfg_idx  <= CFG_FRAME_RANGE;
        cfg_data <= CFG_DATA_W'(range);
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        base_reg  = base;
        range_reg = range;
    endtask

    task automatic wait_drained();
        while (req_q.size() != 0 || in_valid || due_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [RANGE_W-1:0] range,
                             input int count);
        wait_drained();
        repeat (8) @(posedge i_clk);
        write_cfg(base, range);
        for (int i = 0; i < count; i++)
            req_q.push_back(random_request());
    endtask

    // sender: bursts of transactions with random gaps
    int burst_left = 0;
    int gap_left   = 0;
    int n_issued   = 0;

    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || n_accepted == n_issued)) begin
            if (gap_left > 0 || req_q.size() == 0) begin
                if (gap_left > 0)
                    gap_left--;
                in_valid <= 1'b0;
            end else begin
                in_data  <= req_q.pop_front();
                in_valid <= 1'b1;
                n_issued++;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(12);
                    gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // receiver: stall density changes per stretch, plus one long hold-off
    int  stall_pct = 0;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            mode_left = $urandom_range(20, 80);
            case ($urandom_range(4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 30;
                3:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_resp predicted;
        t_resp oldest;
        if (i_rst_n) begin
            if (in_valid && !in_stall) begin
                serve_request(in_data, predicted);
                due_q.push_back(predicted);
                n_accepted++;
            end
            if (out_valid && !out_stall) begin
                if (due_q.size() == 0) begin
                    $display("%0t unexpected transaction: frame_address %h status %0d",
                             $time, out_data.frame_address, out_data.status);
                    mismatches++;
                end else begin
                    oldest = due_q.pop_front();
                    if (out_data.frame_address !== oldest.frame_address) begin
                        $display("%0t frame_address expected %h actual %h",
                                 $time, oldest.frame_address, out_data.frame_address);
                        mismatches++;
                    end
                    if (out_data.status !== oldest.status) begin
                        $display("%0t status expected %0d actual %0d",
                                 $time, oldest.status, out_data.status);
                        mismatches++;
                    end
                end
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < MAP_FRAMES; i++)
            frame_used[i] = 1'b0;
        for (int k = 0; k < BATCH_SIZE; k++) begin
            batch_addr[k] = '0;
            batch_ok[k]   = 1'b0;
        end
        batch_pos = BATCH_SIZE;
        base_reg  = BASE_RESET;
        range_reg = RANGE_RESET;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // taken while the map clear is still running
        write_cfg(32'h0, 11'd1024);

        // first refill, free of a batched frame, unaligned free, free of the last map frame, out of map frees
        req_q.push_back(make_req(REQ_ALLOC, 32'h0000_0000));
        req_q.push_back(make_req(REQ_ALLOC, 32'hFFFF_FFFF));
        req_q.push_back(make_req(REQ_FREE,  32'h0000_0000));
        req_q.push_back(make_req(REQ_FREE,  32'h0000_1FFF));
        req_q.push_back(make_req(REQ_FREE,  32'hFFFF_FFFF));
        req_q.push_back(make_req(REQ_FREE,  32'h003F_F000));
        req_q.push_back(make_req(REQ_FREE,  32'h0040_0000));
        // drain the batch and refill, handing freed frames out again
        for (int i = 0; i < 19; i++)
            req_q.push_back(make_req(REQ_ALLOC, $urandom()));

        // clamped count with wrapping addresses
        run_phase(32'hFFFF_F000, 11'd2047, 80);
        run_phase($urandom() & 32'hFFFF_F000, 11'd1, 60);
        // no managed frames at all
        run_phase(32'h0000_5000, 11'd0, 40);
        // small map that runs dry
        run_phase($urandom() & 32'hFFFF_F000, 11'd25, 80);
        run_phase($urandom(), RANGE_W'($urandom_range(1, 1024)), 80);
        run_phase(32'h0, 11'd1024, 210);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
